/* hw/rtl/quota_and_rate_admission_monitor_defines.svh */
// Assertion macros for the quota and rate admission monitor checkers.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef QUOTA_AND_RATE_ADMISSION_MONITOR_DEFINES_SVH
`define QUOTA_AND_RATE_ADMISSION_MONITOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define QRAM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qram check failed in the same cycle");

// Next-cycle implication, off during reset.
`define QRAM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qram check failed in the following cycle");

`endif

/* hw/rtl/qram_pkg.sv */
// Shared types, codes and constants of the quota and rate admission monitor.
// No dependencies.
package qram_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 416;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_ADMIT     = 3'd2,
    CMD_RECORD    = 3'd3,
    CMD_TICK      = 3'd4,
    CMD_CLR_STATS = 3'd5,
    CMD_BUF_UPD   = 3'd6
  } cmd_e;

  // register indexes, byte address = 4 * index
  localparam logic [1:0] REG_MEM_LIMIT_MB  = 2'd0;
  localparam logic [1:0] REG_RATE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_MEM_LIMIT_ON  = 2'd2;
  localparam logic [1:0] REG_RATE_LIMIT_ON = 2'd3;

  localparam logic [11:0] MemLimitMbRst = 12'd100;
  localparam logic [19:0] RateLimitRst  = 20'd10000;

  typedef struct packed {
    logic [11:0] mem_limit_mb;
    logic [19:0] rate_limit;
    logic        mem_limit_on;
    logic        rate_limit_on;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] amount;
    logic [31:0] proc_time;
    logic [31:0] buf_size;
    logic [31:0] buf_used;
  } item_t;

  typedef struct packed {
    logic [31:0] bytes_held;
    logic [31:0] bytes_peak;
    logic [19:0] msgs_in_window;
    logic [63:0] processed_count;
    logic [63:0] dropped_count;
    logic [63:0] byte_sum;
    logic [63:0] time_sum;
    logic [31:0] time_min;
    logic [31:0] time_max;
    logic [31:0] buffer_capacity;
    logic [31:0] buffer_level;
  } stats_t;

endpackage

/* hw/rtl/qram_cfg.sv */
// Configuration registers of the admission monitor behind an APB-style port.
// Depends on qram_pkg.
module qram_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qram_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output qram_pkg::cfg_t              cfg_o
);
  import qram_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mem_limit_mb  <= MemLimitMbRst;
      cfg_q.rate_limit    <= RateLimitRst;
      cfg_q.mem_limit_on  <= 1'b1;
      cfg_q.rate_limit_on <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MEM_LIMIT_MB:  cfg_q.mem_limit_mb  <= pwdata[11:0];
        REG_RATE_LIMIT:    cfg_q.rate_limit    <= pwdata[19:0];
        REG_MEM_LIMIT_ON:  cfg_q.mem_limit_on  <= pwdata[0];
        REG_RATE_LIMIT_ON: cfg_q.rate_limit_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MEM_LIMIT_MB:  prdata = {20'd0, cfg_q.mem_limit_mb};
      REG_RATE_LIMIT:    prdata = {12'd0, cfg_q.rate_limit};
      REG_MEM_LIMIT_ON:  prdata = {31'd0, cfg_q.mem_limit_on};
      REG_RATE_LIMIT_ON: prdata = {31'd0, cfg_q.rate_limit_on};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/qram_state.sv */
// Counter and statistics state of the admission monitor, updated by one word a cycle while en_i is high.
// Depends on qram_pkg.
module qram_state (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  qram_pkg::item_t item_i,
  input  qram_pkg::cfg_t  cfg_i,
  output qram_pkg::stats_t st_o,
  output logic            acc_o
);
  import qram_pkg::*;

  // everything clears except min time, which starts at all ones
  localparam stats_t StatsRst = '{time_min: 32'hFFFF_FFFF, default: '0};

  stats_t      st_q, st_d;
  logic        acc_q, acc_d;
  logic [32:0] alloc_sum;
  logic [31:0] limit_bytes;
  logic [31:0] held_new;

  assign limit_bytes = {cfg_i.mem_limit_mb, 20'd0};
  assign alloc_sum   = {1'b0, st_q.bytes_held} + {1'b0, item_i.amount};
  assign held_new    = alloc_sum[32] ? 32'hFFFF_FFFF : alloc_sum[31:0];

  always_comb begin
    st_d  = st_q;
    acc_d = 1'b1;
    case (item_i.command)
      CMD_ALLOC: begin
        if (cfg_i.mem_limit_on && (alloc_sum > {1'b0, limit_bytes})) begin
          acc_d = 1'b0;
        end else begin
          st_d.bytes_held = held_new;
          if (held_new > st_q.bytes_peak) st_d.bytes_peak = held_new;
        end
      end
      CMD_FREE: begin
        // floor at zero
        st_d.bytes_held = (st_q.bytes_held >= item_i.amount) ?
                          st_q.bytes_held - item_i.amount : 32'd0;
      end
      CMD_ADMIT: begin
        if (cfg_i.rate_limit_on && (st_q.msgs_in_window >= cfg_i.rate_limit)) begin
          acc_d              = 1'b0;
          st_d.dropped_count = st_q.dropped_count + 64'd1;
        end
      end
      CMD_RECORD: begin
        if (st_q.msgs_in_window != 20'hF_FFFF)
          st_d.msgs_in_window = st_q.msgs_in_window + 20'd1;
        st_d.processed_count = st_q.processed_count + 64'd1;
        st_d.byte_sum        = st_q.byte_sum + {32'd0, item_i.amount};
        st_d.time_sum        = st_q.time_sum + {32'd0, item_i.proc_time};
        if (item_i.proc_time < st_q.time_min) st_d.time_min = item_i.proc_time;
        if (item_i.proc_time > st_q.time_max) st_d.time_max = item_i.proc_time;
      end
      CMD_TICK: begin
        st_d.msgs_in_window = 20'd0;
      end
      CMD_CLR_STATS: begin
        st_d.processed_count = 64'd0;
        st_d.dropped_count   = 64'd0;
        st_d.byte_sum        = 64'd0;
        st_d.time_sum        = 64'd0;
        st_d.time_min        = 32'hFFFF_FFFF;
        st_d.time_max        = 32'd0;
        st_d.bytes_peak      = st_q.bytes_held;
      end
      CMD_BUF_UPD: begin
        st_d.buffer_capacity = item_i.buf_size;
        st_d.buffer_level    = item_i.buf_used;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StatsRst;
      acc_q <= 1'b1;
    end else if (en_i) begin
      st_q  <= st_d;
      acc_q <= acc_d;
    end
  end

  assign st_o  = st_q;
  assign acc_o = acc_q;

endmodule

/* hw/rtl/qram_health.sv */
// Health flags of the admission monitor: exact 75/90 percent and 1/5 percent tests.
// Depends on qram_pkg.
module qram_health (
  input  qram_pkg::stats_t st_i,
  input  qram_pkg::cfg_t   cfg_i,
  output logic [7:0]       flags_o
);
  import qram_pkg::*;

  // bit 0 warn, bit 1 crit; used*100 against limit*90 and limit*75
  function automatic logic [1:0] level_code(input logic [31:0] used,
                                            input logic [31:0] limit);
    logic [38:0] u100;
    logic [38:0] l90;
    logic [38:0] l75;
    logic [1:0]  code;
    u100 = {7'd0, used}  * 39'd100;
    l90  = {7'd0, limit} * 39'd90;
    l75  = {7'd0, limit} * 39'd75;
    if (u100 > l90)      code = 2'b10;
    else if (u100 > l75) code = 2'b01;
    else                 code = 2'b00;
    return code;
  endfunction

  logic [64:0] total;
  logic [71:0] drop100;
  logic [71:0] total5;
  logic [71:0] total_w;
  logic [1:0]  mem_code, rate_code, buf_code, drop_code;

  assign total   = {1'b0, st_i.processed_count} + {1'b0, st_i.dropped_count};
  assign drop100 = {8'd0, st_i.dropped_count} * 72'd100;
  assign total5  = {7'd0, total} * 72'd5;
  assign total_w = {7'd0, total};

  always_comb begin
    mem_code  = cfg_i.mem_limit_on ?
                level_code(st_i.bytes_held, {cfg_i.mem_limit_mb, 20'd0}) : 2'b00;
    rate_code = cfg_i.rate_limit_on ?
                level_code({12'd0, st_i.msgs_in_window}, {12'd0, cfg_i.rate_limit}) : 2'b00;
    buf_code  = (st_i.buffer_capacity != 32'd0) ?
                level_code(st_i.buffer_level, st_i.buffer_capacity) : 2'b00;
    drop_code = 2'b00;
    if (total != 65'd0) begin
      if (drop100 > total5)       drop_code = 2'b10;
      else if (drop100 > total_w) drop_code = 2'b01;
    end
  end

  assign flags_o = {drop_code, buf_code, rate_code, mem_code};

endmodule

/* hw/rtl/quota_and_rate_admission_monitor.sv */
// Quota and rate admission monitor: one event word in, one result word out.
// An accepted event word is held in the input register, applied to the state, then registered as its result.
// Throughput: one word per cycle while the result stream does not stall the result register.
// Reset: counters and sums clear, min time goes to all ones, registers take their defaults.
// Depends on qram_pkg, qram_cfg, qram_state and qram_health.
module quota_and_rate_admission_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB-style configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qram_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // event stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // amount[31:0], proc_time[63:32], buf_size[95:64], buf_used[127:96]
  input  logic [qram_pkg::InDataW-1:0]   s_axis_tdata,
  // command[2:0]
  input  logic [qram_pkg::CmdW-1:0]      s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // mem_in_use[31:0], mem_peak[63:32], window_count[83:64],
  // total_processed[147:84], total_dropped[211:148], total_bytes[275:212],
  // total_time[339:276], min_time[371:340], max_time[403:372],
  // health_flags[411:404], healthy[412], zero fill[415:413]
  output logic [qram_pkg::OutDataW-1:0]  m_axis_tdata,
  // accepted[0]
  output logic                           m_axis_tuser
);
  import qram_pkg::*;

  cfg_t        cfg;
  stats_t      st;
  logic        acc;
  logic [7:0]  flags;

  item_t       item_q;
  logic        item_v_q;
  logic        pend_q;     // state holds an update whose result is not yet out
  logic        out_v_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic        out_acc_q;

  logic        s_acc, mv_state, mv_out, out_free;
  logic [31:0] min_time;

  assign pready = 1'b1;

  qram_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // pipeline moves: input register -> state -> result register
  assign out_free      = !out_v_q || m_axis_tready;
  assign mv_out        = pend_q && out_free;
  assign mv_state      = item_v_q && (!pend_q || mv_out);
  assign s_axis_tready = !item_v_q || mv_state;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  qram_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mv_state),
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_o   (st),
    .acc_o  (acc)
  );

  qram_health u_health (
    .st_i    (st),
    .cfg_i   (cfg),
    .flags_o (flags)
  );

  // min time reads zero until something has been recorded
  assign min_time = ((st.time_min == 32'hFFFF_FFFF) && (st.time_max != 32'hFFFF_FFFF)) ?
                    32'd0 : st.time_min;

  assign out_data_d = {3'd0, ((flags & 8'hAA) == 8'h00), flags,
                       st.time_max, min_time, st.time_sum, st.byte_sum,
                       st.dropped_count, st.processed_count, st.msgs_in_window,
                       st.bytes_peak, st.bytes_held};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      pend_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (s_acc)         item_v_q <= 1'b1;
      else if (mv_state) item_v_q <= 1'b0;
      if (mv_state)      pend_q <= 1'b1;
      else if (mv_out)   pend_q <= 1'b0;
      if (mv_out)             out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q.command   <= cmd_e'(s_axis_tuser);
      item_q.amount    <= s_axis_tdata[31:0];
      item_q.proc_time <= s_axis_tdata[63:32];
      item_q.buf_size  <= s_axis_tdata[95:64];
      item_q.buf_used  <= s_axis_tdata[127:96];
    end
    if (mv_out) begin
      out_data_q <= out_data_d;
      out_acc_q  <= acc;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_acc_q;

endmodule

/* hw/rtl/qram_checker.sv */
// Port-level checks on the result stream of the admission monitor, bound to the top level.
// Depends on qram_pkg and the assertion macros header.
`include "quota_and_rate_admission_monitor_defines.svh"

module qram_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [qram_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import qram_pkg::*;

  logic stalled;
  assign stalled = m_axis_tvalid && !m_axis_tready;

  // hold a stalled word
  `QRAM_ASSERT_NEXT(a_valid_held, stalled, m_axis_tvalid)
  `QRAM_ASSERT_NEXT(a_word_held, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // healthy must be the inverse of any critical flag
  `QRAM_ASSERT_NOW(a_healthy_match, m_axis_tvalid, m_axis_tdata[412] == !(m_axis_tdata[405] || m_axis_tdata[407] || m_axis_tdata[409] || m_axis_tdata[411]))

  // warn and crit of one group are never raised together
  `QRAM_ASSERT_NOW(a_warn_crit_excl, m_axis_tvalid, !(m_axis_tdata[404] && m_axis_tdata[405]) && !(m_axis_tdata[406] && m_axis_tdata[407]) && !(m_axis_tdata[408] && m_axis_tdata[409]) && !(m_axis_tdata[410] && m_axis_tdata[411]))

endmodule

bind quota_and_rate_admission_monitor qram_checker u_qram_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/quota_and_rate_admission_monitor_tb.sv */
// Self-checking testbench for the quota and rate admission monitor.
// Drives event words and register writes, predicts every result word and compares.
// Depends on qram_pkg and the monitor RTL only.
`timescale 1ns / 1ps

module quota_and_rate_admission_monitor_tb;
  import qram_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 122;
  localparam int unsigned IdlePct    = 31;
  localparam int unsigned ErrShown   = 10;
  localparam logic [CmdW-1:0] CmdUnused = 3'd7;

  typedef struct packed {
    logic        accepted;
    logic [31:0] mem_in_use;
    logic [31:0] mem_peak;
    logic [19:0] window_count;
    logic [63:0] total_processed;
    logic [63:0] total_dropped;
    logic [63:0] total_bytes;
    logic [63:0] total_time;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [7:0]  health_flags;
    logic        healthy;
    logic [2:0]  fill;
  } monitor_report_t;

  class admission_tracker;
    cfg_t            cfg;
    stats_t          st;
    monitor_report_t due_reports[$];
    int unsigned     events_taken;
    int unsigned     reports_seen;
    int unsigned     refusals;
    int unsigned     mismatches;

    function new();
      cfg.mem_limit_mb  = MemLimitMbRst;
      cfg.rate_limit    = RateLimitRst;
      cfg.mem_limit_on  = 1'b1;
      cfg.rate_limit_on = 1'b1;
      st                = '0;
      st.time_min       = '1;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MEM_LIMIT_MB:  cfg.mem_limit_mb  = value[11:0];
        REG_RATE_LIMIT:    cfg.rate_limit    = value[19:0];
        REG_MEM_LIMIT_ON:  cfg.mem_limit_on  = value[0];
        REG_RATE_LIMIT_ON: cfg.rate_limit_on = value[0];
        default: ;
      endcase
    endfunction

    // warn when above 75% of cap, critical when above 90%
    function logic [1:0] usage_level(logic [63:0] used, logic [63:0] cap);
      if (used * 64'd100 > cap * 64'd90) return 2'b10;
      if (used * 64'd100 > cap * 64'd75) return 2'b01;
      return 2'b00;
    endfunction

    function void take_event(logic [CmdW-1:0] cmd, logic [InDataW-1:0] data);
      logic [31:0]     amount;
      logic [31:0]     ptime;
      logic [63:0]     quota;
      logic [63:0]     sum;
      logic [71:0]     total;
      logic [71:0]     drop_scaled;
      monitor_report_t rep;
      amount = data[31:0];
      ptime  = data[63:32];
      quota  = {52'd0, cfg.mem_limit_mb} << 20;
      rep    = '0;
      rep.accepted = 1'b1;
      case (cmd)
        CMD_ALLOC: begin
          sum = {32'd0, st.bytes_held} + {32'd0, amount};
          if (cfg.mem_limit_on && sum > quota) begin
            rep.accepted = 1'b0;
          end else begin
            st.bytes_held = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            if (st.bytes_held > st.bytes_peak) st.bytes_peak = st.bytes_held;
          end
        end
        CMD_FREE: begin
          st.bytes_held = (st.bytes_held >= amount) ? st.bytes_held - amount : 32'd0;
        end
        CMD_ADMIT: begin
          if (cfg.rate_limit_on && st.msgs_in_window >= cfg.rate_limit) begin
            rep.accepted = 1'b0;
            st.dropped_count = st.dropped_count + 64'd1;
          end
        end
        CMD_RECORD: begin
          if (st.msgs_in_window != 20'hFFFFF) st.msgs_in_window = st.msgs_in_window + 20'd1;
          st.processed_count = st.processed_count + 64'd1;
          st.byte_sum        = st.byte_sum + {32'd0, amount};
          st.time_sum        = st.time_sum + {32'd0, ptime};
          if (ptime < st.time_min) st.time_min = ptime;
          if (ptime > st.time_max) st.time_max = ptime;
        end
        CMD_TICK: begin
          st.msgs_in_window = '0;
        end
        CMD_CLR_STATS: begin
          st.processed_count = '0;
          st.dropped_count   = '0;
          st.byte_sum        = '0;
          st.time_sum        = '0;
          st.time_min        = '1;
          st.time_max        = '0;
          st.bytes_peak      = st.bytes_held;
        end
        CMD_BUF_UPD: begin
          st.buffer_capacity = data[95:64];
          st.buffer_level    = data[127:96];
        end
        default: ;
      endcase

      if (cfg.mem_limit_on) rep.health_flags[1:0] = usage_level({32'd0, st.bytes_held}, quota);
      if (cfg.rate_limit_on)
        rep.health_flags[3:2] = usage_level({44'd0, st.msgs_in_window}, {44'd0, cfg.rate_limit});
      if (st.buffer_capacity != 0)
        rep.health_flags[5:4] = usage_level({32'd0, st.buffer_level},
                                            {32'd0, st.buffer_capacity});
      // drop ratio against the exact sum of processed and dropped
      total       = {8'd0, st.processed_count} + {8'd0, st.dropped_count};
      drop_scaled = {8'd0, st.dropped_count} * 72'd100;
      if (total != 0) begin
        if (drop_scaled > total * 72'd5) rep.health_flags[7] = 1'b1;
        else if (drop_scaled > total) rep.health_flags[6] = 1'b1;
      end
      rep.healthy = ((rep.health_flags & 8'hAA) == 8'h00);

      rep.mem_in_use      = st.bytes_held;
      rep.mem_peak        = st.bytes_peak;
      rep.window_count    = st.msgs_in_window;
      rep.total_processed = st.processed_count;
      rep.total_dropped   = st.dropped_count;
      rep.total_bytes     = st.byte_sum;
      rep.total_time      = st.time_sum;
      // nothing recorded yet reads as zero
      rep.min_time = (st.time_min == '1 && st.time_max != '1) ? 32'd0 : st.time_min;
      rep.max_time = st.time_max;
      if (!rep.accepted) refusals++;
      events_taken++;
      due_reports.push_back(rep);
    endfunction

    function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (got === want) return 1'b0;
      if (mismatches < ErrShown)
        $display("report %0d: %s expected 0x%0h, got 0x%0h", reports_seen, name, want, got);
      return 1'b1;
    endfunction

    function void match_report(logic [OutDataW-1:0] word, logic acc);
      monitor_report_t got;
      monitor_report_t want;
      bit              bad;
      got.accepted        = acc;
      got.mem_in_use      = word[31:0];
      got.mem_peak        = word[63:32];
      got.window_count    = word[83:64];
      got.total_processed = word[147:84];
      got.total_dropped   = word[211:148];
      got.total_bytes     = word[275:212];
      got.total_time      = word[339:276];
      got.min_time        = word[371:340];
      got.max_time        = word[403:372];
      got.health_flags    = word[411:404];
      got.healthy         = word[412];
      got.fill            = word[415:413];
      reports_seen++;
      if (due_reports.size() == 0) begin
        if (mismatches < ErrShown)
          $display("report %0d arrived with no event outstanding", reports_seen);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      bad  = 1'b0;
      bad |= field_differs("accepted", want.accepted, got.accepted);
      bad |= field_differs("mem_in_use", want.mem_in_use, got.mem_in_use);
      bad |= field_differs("mem_peak", want.mem_peak, got.mem_peak);
      bad |= field_differs("window_count", want.window_count, got.window_count);
      bad |= field_differs("total_processed", want.total_processed, got.total_processed);
      bad |= field_differs("total_dropped", want.total_dropped, got.total_dropped);
      bad |= field_differs("total_bytes", want.total_bytes, got.total_bytes);
      bad |= field_differs("total_time", want.total_time, got.total_time);
      bad |= field_differs("min_time", want.min_time, got.min_time);
      bad |= field_differs("max_time", want.max_time, got.max_time);
      bad |= field_differs("health_flags", want.health_flags, got.health_flags);
      bad |= field_differs("healthy", want.healthy, got.healthy);
      bad |= field_differs("zero fill", want.fill, got.fill);
      if (bad) mismatches++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [CmdW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  admission_tracker tracker;
  bit               steady;
  int unsigned      cycles;
  int unsigned      phases;

  quota_and_rate_admission_monitor i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, tracker.pending());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.take_event(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.match_report(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = steady || ($urandom_range(99) >= IdlePct);
  end

  task automatic send_event(input logic [CmdW-1:0] cmd, input logic [31:0] amount,
                            input logic [31:0] ptime, input logic [31:0] bsize,
                            input logic [31:0] bused);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {$urandom(), $urandom(), $urandom(), $urandom()};
      @(negedge clk_i);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = {bused, bsize, ptime, amount};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender off until every report has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_event();
    logic [CmdW-1:0] cmd;
    logic [31:0]     amount;
    logic [31:0]     ptime;
    logic [31:0]     bsize;
    logic [31:0]     bused;
    logic [31:0]     quota;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 22)      cmd = CMD_ALLOC;
    else if (pick < 36) cmd = CMD_FREE;
    else if (pick < 56) cmd = CMD_ADMIT;
    else if (pick < 78) cmd = CMD_RECORD;
    else if (pick < 85) cmd = CMD_TICK;
    else if (pick < 89) cmd = CMD_CLR_STATS;
    else if (pick < 97) cmd = CMD_BUF_UPD;
    else                cmd = CmdUnused;
    // draw half of the sizes from up to an eighth or up to half of the quota so its thresholds are crossed often
    quota = {tracker.cfg.mem_limit_mb, 20'd0};
    case ($urandom_range(3))
      0:       amount = $urandom();
      1:       amount = $urandom_range(quota >> 3);
      2:       amount = $urandom_range(quota >> 1);
      default: amount = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
    ptime = ($urandom_range(1) != 0) ? $urandom() : $urandom_range(5000);
    case ($urandom_range(3))
      0:       bsize = 32'd0;
      1:       bsize = $urandom_range(200, 1);
      default: bsize = $urandom();
    endcase
    bused = ($urandom_range(3) != 0) ? $urandom_range(bsize) : $urandom();
    send_event(cmd, amount, ptime, bsize, bused);
  endtask

  task automatic run_phase(input logic [11:0] mb, input logic [19:0] rate,
                           input logic mem_on, input logic rate_on,
                           input bit no_idle, input bit pause_mid);
    drain();
    apb_write(REG_MEM_LIMIT_MB, {20'd0, mb});
    apb_write(REG_RATE_LIMIT, {12'd0, rate});
    apb_write(REG_MEM_LIMIT_ON, {31'd0, mem_on});
    apb_write(REG_RATE_LIMIT_ON, {31'd0, rate_on});
    steady = no_idle;
    phases++;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      if (pause_mid && i == PhaseItems / 2) drain();
      random_event();
    end
    steady = 1'b0;
  endtask

  initial begin
    tracker       = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: 100 MiB quota, 10000 messages per window
    send_event(CmdUnused, '1, '1, '1, '1);
    send_event(CMD_ALLOC, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ALLOC, 32'd83886080, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ALLOC, 32'd12582912, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ALLOC, '1, 32'd0, 32'd0, 32'd0);
    send_event(CMD_FREE, '1, 32'd0, 32'd0, 32'd0);
    send_event(CMD_RECORD, '1, '1, 32'd0, 32'd0);
    send_event(CMD_RECORD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ADMIT, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_TICK, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_CLR_STATS, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_BUF_UPD, 32'd0, 32'd0, 32'd100, 32'd76);
    send_event(CMD_BUF_UPD, 32'd0, 32'd0, 32'd100, 32'd91);
    send_event(CMD_BUF_UPD, 32'd0, 32'd0, '1, '1);
    send_event(CMD_BUF_UPD, 32'd0, 32'd0, 32'd0, '1);

    // tight window: fill it, refuse, then reopen with a tick
    drain();
    apb_write(REG_RATE_LIMIT, 32'd2);
    send_event(CMD_RECORD, 32'd64, 32'd10, 32'd0, 32'd0);
    send_event(CMD_RECORD, 32'd64, 32'd20, 32'd0, 32'd0);
    send_event(CMD_ADMIT, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_TICK, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ADMIT, 32'd0, 32'd0, 32'd0, 32'd0);

    // zero limits: any use is critical, no use raises nothing
    drain();
    apb_write(REG_RATE_LIMIT, 32'd0);
    send_event(CMD_ADMIT, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_RECORD, 32'd1, 32'd5, 32'd0, 32'd0);
    drain();
    apb_write(REG_MEM_LIMIT_MB, 32'd0);
    send_event(CMD_ALLOC, 32'd0, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ALLOC, 32'd1, 32'd0, 32'd0, 32'd0);

    // enforcement off: allocs always fit and saturate, admits always pass
    drain();
    apb_write(REG_MEM_LIMIT_ON, 32'd0);
    send_event(CMD_ALLOC, '1, 32'd0, 32'd0, 32'd0);
    send_event(CMD_ALLOC, 32'd5, 32'd0, 32'd0, 32'd0);
    drain();
    apb_write(REG_RATE_LIMIT_ON, 32'd0);
    send_event(CMD_ADMIT, 32'd0, 32'd0, 32'd0, 32'd0);

    run_phase(12'd1, 20'd4, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(12'd4095, 20'hFFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(12'd0, 20'd0, 1'b1, 1'b1, 1'b0, 1'b1);
    run_phase(12'($urandom_range(8, 1)), 20'($urandom_range(10, 1)), 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(12'($urandom_range(4095)), 20'($urandom()), 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(12'd2, 20'd3, 1'b1, 1'b1, 1'b0, 1'b1);
    drain();

    $display("Covered %0d events (%0d refused) and %0d reports over %0d random phases.",
             tracker.events_taken, tracker.refusals, tracker.reports_seen, phases);
    $display("Quota, rate window, buffer and drop health checked at zero and full limits.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatched reports, %0d outstanding", tracker.mismatches,
               tracker.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
